[sv/cao_pkg.sv]
`default_nettype none

package cao_pkg;

  // field widths
  localparam int TEMP_W     = 12;
  localparam int HUM_W      = 10;
  localparam int CODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // alert set and result limit per sample
  localparam int NUM_ALERTS  = 10;
  localparam int MAX_RESULTS = 6;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // crossing counter levels
  localparam int CROSS_LIMIT_DEF  = 5;
  localparam int OSC_LEVEL        = 4;
  localparam int TEMP_CLEAR_LEVEL = 2;
  localparam int HUM_CLEAR_LEVEL  = 1;

  // opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_EN   = 3'd4;

  // register reset values
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd270;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 12'sd200;
  localparam logic [HUM_W-1:0]         HUM_HIGH_RST  = 10'd900;
  localparam logic [HUM_W-1:0]         HUM_LOW_RST   = 10'd600;

  // zone codes
  localparam logic [1:0] ZONE_NONE  = 2'd0;
  localparam logic [1:0] ZONE_LOW   = 2'd1;
  localparam logic [1:0] ZONE_RANGE = 2'd2;
  localparam logic [1:0] ZONE_HIGH  = 2'd3;

  // alert codes, also bit positions in the alert mask
  localparam logic [CODE_W-1:0] AL_TEMP_HIGH     = 4'd0;
  localparam logic [CODE_W-1:0] AL_TEMP_LOW      = 4'd1;
  localparam logic [CODE_W-1:0] AL_TEMP_OK       = 4'd2;
  localparam logic [CODE_W-1:0] AL_HUM_HIGH      = 4'd3;
  localparam logic [CODE_W-1:0] AL_HUM_LOW       = 4'd4;
  localparam logic [CODE_W-1:0] AL_HUM_OK        = 4'd5;
  localparam logic [CODE_W-1:0] AL_OSC_TEMP_HIGH = 4'd6;
  localparam logic [CODE_W-1:0] AL_OSC_TEMP_LOW  = 4'd7;
  localparam logic [CODE_W-1:0] AL_OSC_HUM_HIGH  = 4'd8;
  localparam logic [CODE_W-1:0] AL_OSC_HUM_LOW   = 4'd9;

  // oscillation flag bits
  localparam int F_THIGH = 0;
  localparam int F_TLOW  = 1;
  localparam int F_HHIGH = 2;
  localparam int F_HLOW  = 3;

  typedef logic [NUM_ALERTS-1:0] alert_mask_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_high;
    logic signed [TEMP_W-1:0] temp_low;
    logic [HUM_W-1:0]         hum_high;
    logic [HUM_W-1:0]         hum_low;
    logic                     hyst_en;
  } cfg_t;

  typedef struct packed {
    logic                     opcode;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic                     alerts_locked;
  } item_t;

endpackage

`default_nettype wire

[sv/cao_eval.sv]
`default_nettype none

module cao_eval import cao_pkg::*; #(
  parameter int CROSS_LIMIT = CROSS_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire item_t       item,
  input  wire logic        commit,
  output alert_mask_t      alert_mask
);

  localparam int CNT_W = $clog2(CROSS_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(CROSS_LIMIT);
  localparam logic [CNT_W-1:0] CNT_OSC  = CNT_W'(OSC_LEVEL);
  localparam logic [CNT_W-1:0] CNT_TCLR = CNT_W'(TEMP_CLEAR_LEVEL);
  localparam logic [CNT_W-1:0] CNT_HCLR = CNT_W'(HUM_CLEAR_LEVEL);

  logic             ths_r, tls_r, hhs_r, hls_r;
  logic             ths_nxt, tls_nxt, hhs_nxt, hls_nxt;
  logic [1:0]       tzone_r, hzone_r, tzone_nxt, hzone_nxt;
  logic [CNT_W-1:0] trise_r, tfall_r, hrise_r, hfall_r;
  logic [CNT_W-1:0] trise_nxt, tfall_nxt, hrise_nxt, hfall_nxt;
  logic [3:0]       osc_r, shown_r, osc_nxt, shown_nxt;
  alert_mask_t      raw;

  always_comb begin
    logic                     lk;
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0]         h;
    logic                     t_hi, t_lo, t_in, h_hi, h_lo, h_in;

    lk = item.alerts_locked;
    t  = item.temperature;
    h  = item.humidity;
    t_hi = t > cfg.temp_high;
    t_lo = t < cfg.temp_low;
    t_in = (t > cfg.temp_low) && (t < cfg.temp_high);
    h_hi = h > cfg.hum_high;
    h_lo = h < cfg.hum_low;
    h_in = (h > cfg.hum_low) && (h < cfg.hum_high);

    ths_nxt = ths_r;  tls_nxt = tls_r;  hhs_nxt = hhs_r;  hls_nxt = hls_r;
    tzone_nxt = tzone_r;  hzone_nxt = hzone_r;
    trise_nxt = trise_r;  tfall_nxt = tfall_r;
    hrise_nxt = hrise_r;  hfall_nxt = hfall_r;
    osc_nxt = osc_r;  shown_nxt = shown_r;
    raw = '0;

    if (item.opcode == OP_TICK) begin
      if (cfg.hyst_en) begin
        if (trise_r != '0) trise_nxt = trise_r - 1'b1;
        if (tfall_r != '0) tfall_nxt = tfall_r - 1'b1;
        if (hrise_r != '0) hrise_nxt = hrise_r - 1'b1;
        if (hfall_r != '0) hfall_nxt = hfall_r - 1'b1;
      end
    end else begin
      // plain temperature alarms, all gated by the t-high oscillation flag
      if (t_hi && !ths_nxt && !osc_r[F_THIGH]) begin
        raw[AL_TEMP_HIGH] = !lk;
        ths_nxt = 1'b1;  tls_nxt = 1'b0;
      end
      if (t_lo && !tls_nxt && !osc_r[F_THIGH]) begin
        raw[AL_TEMP_LOW] = !lk;
        tls_nxt = 1'b1;  ths_nxt = 1'b0;
      end
      if (t_in && !osc_r[F_THIGH] && (ths_nxt || tls_nxt)) begin
        raw[AL_TEMP_OK] = !lk;
        ths_nxt = 1'b0;  tls_nxt = 1'b0;
      end
      // plain humidity alarms
      if (h_hi && !hhs_nxt && !osc_r[F_HHIGH]) begin
        raw[AL_HUM_HIGH] = !lk;
        hhs_nxt = 1'b1;  hls_nxt = 1'b0;
      end
      if (h_lo && !hls_nxt && !osc_r[F_HLOW]) begin
        raw[AL_HUM_LOW] = !lk;
        hls_nxt = 1'b1;  hhs_nxt = 1'b0;
      end
      if (h_in && !osc_r[F_HLOW] && (hhs_nxt || hls_nxt)) begin
        raw[AL_HUM_OK] = !lk;
        hhs_nxt = 1'b0;  hls_nxt = 1'b0;
      end

      if (cfg.hyst_en) begin
        // temperature crossings
        if (t_hi) begin
          if (((tzone_nxt == ZONE_RANGE) || (tzone_nxt == ZONE_LOW)) && (trise_nxt < CNT_MAX))
            trise_nxt = trise_nxt + 1'b1;
          tzone_nxt = ZONE_HIGH;
        end
        if (trise_nxt == CNT_OSC) begin
          osc_nxt[F_THIGH] = 1'b1;
          if (!lk && !shown_nxt[F_THIGH]) begin
            raw[AL_OSC_TEMP_HIGH] = 1'b1;
            shown_nxt[F_THIGH] = 1'b1;
            ths_nxt = 1'b0;  tls_nxt = 1'b0;
          end
        end
        if (trise_nxt <= CNT_TCLR) begin
          osc_nxt[F_THIGH] = 1'b0;  shown_nxt[F_THIGH] = 1'b0;
        end
        if (t_in) tzone_nxt = ZONE_RANGE;
        if (t_lo) begin
          if (((tzone_nxt == ZONE_RANGE) || (tzone_nxt == ZONE_HIGH)) && (tfall_nxt < CNT_MAX))
            tfall_nxt = tfall_nxt + 1'b1;
          tzone_nxt = ZONE_LOW;
        end
        if (tfall_nxt == CNT_OSC) begin
          osc_nxt[F_TLOW] = 1'b1;
          if (!lk && !shown_nxt[F_TLOW]) begin
            raw[AL_OSC_TEMP_LOW] = 1'b1;
            shown_nxt[F_TLOW] = 1'b1;
            ths_nxt = 1'b0;  tls_nxt = 1'b0;
          end
        end
        if (tfall_nxt <= CNT_TCLR) begin
          osc_nxt[F_TLOW] = 1'b0;  shown_nxt[F_TLOW] = 1'b0;
        end
        // humidity crossings, flags only set when the alert goes out
        if (h_hi) begin
          if (((hzone_nxt == ZONE_RANGE) || (hzone_nxt == ZONE_LOW)) && (hrise_nxt < CNT_MAX))
            hrise_nxt = hrise_nxt + 1'b1;
          hzone_nxt = ZONE_HIGH;
        end
        if ((hrise_nxt == CNT_OSC) && !lk && !shown_nxt[F_HHIGH]) begin
          raw[AL_OSC_HUM_HIGH] = 1'b1;
          shown_nxt[F_HHIGH] = 1'b1;  osc_nxt[F_HHIGH] = 1'b1;
          hhs_nxt = 1'b0;  hls_nxt = 1'b0;
        end
        if (hrise_nxt <= CNT_HCLR) begin
          osc_nxt[F_HHIGH] = 1'b0;  shown_nxt[F_HHIGH] = 1'b0;
        end
        if (h_in) hzone_nxt = ZONE_RANGE;
        if (h_lo) begin
          if (((hzone_nxt == ZONE_RANGE) || (hzone_nxt == ZONE_HIGH)) && (hfall_nxt < CNT_MAX))
            hfall_nxt = hfall_nxt + 1'b1;
          hzone_nxt = ZONE_LOW;
        end
        if ((hfall_nxt == CNT_OSC) && !lk && !shown_nxt[F_HLOW]) begin
          raw[AL_OSC_HUM_LOW] = 1'b1;
          osc_nxt[F_HLOW] = 1'b1;  shown_nxt[F_HLOW] = 1'b1;
          hhs_nxt = 1'b0;  hls_nxt = 1'b0;
        end
        if (hfall_nxt <= CNT_HCLR) begin
          osc_nxt[F_HLOW] = 1'b0;  shown_nxt[F_HLOW] = 1'b0;
        end
      end else begin
        osc_nxt[F_HLOW] = 1'b0;
      end
    end
  end

  // keep only the first results of a sample, in code order
  always_comb begin
    logic [RES_CNT_W-1:0] cnt;
    cnt = '0;
    alert_mask = '0;
    for (int i = 0; i < NUM_ALERTS; i++) begin
      if (raw[i] && (cnt < RES_CNT_W'(MAX_RESULTS))) begin
        alert_mask[i] = 1'b1;
        cnt = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ths_r   <= 1'b0;
      tls_r   <= 1'b0;
      hhs_r   <= 1'b0;
      hls_r   <= 1'b0;
      tzone_r <= ZONE_NONE;
      hzone_r <= ZONE_NONE;
      trise_r <= '0;
      tfall_r <= '0;
      hrise_r <= '0;
      hfall_r <= '0;
      osc_r   <= '0;
      shown_r <= '0;
    end else if (commit) begin
      ths_r   <= ths_nxt;
      tls_r   <= tls_nxt;
      hhs_r   <= hhs_nxt;
      hls_r   <= hls_nxt;
      tzone_r <= tzone_nxt;
      hzone_r <= hzone_nxt;
      trise_r <= trise_nxt;
      tfall_r <= tfall_nxt;
      hrise_r <= hrise_nxt;
      hfall_r <= hfall_nxt;
      osc_r   <= osc_nxt;
      shown_r <= shown_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/cao_drain.sv]
`default_nettype none

module cao_drain import cao_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire alert_mask_t        load_mask,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CODE_W-1:0]       out_code,
  output logic                    out_last
);

  alert_mask_t mask_r, mask_nxt, rest;

  function automatic logic [CODE_W-1:0] first_set(input alert_mask_t m);
    logic [CODE_W-1:0] idx;
    idx = '0;
    for (int i = NUM_ALERTS - 1; i >= 0; i--) begin
      if (m[i]) idx = CODE_W'(i);
    end
    return idx;
  endfunction

  assign rest      = mask_r & (mask_r - 1'b1);
  assign out_valid = |mask_r;
  assign out_code  = first_set(mask_r);
  assign out_last  = (rest == '0);
  assign can_load  = !out_valid || (out_ready && out_last);

  always_comb begin
    mask_nxt = mask_r;
    if (out_valid && out_ready) mask_nxt = rest;
    if (load) mask_nxt = load_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/climate_alarm_oscillation_monitor.sv]
`default_nettype none

// channel  | ports                                             | handshake
// ---------+---------------------------------------------------+---------------
// input    | in_opcode in_temperature in_humidity              | in_valid/in_ready
//          | in_alerts_locked                                  |
// result   | out_alert_code out_last_alert                     | out_valid/out_ready
// config   | cfg_index cfg_data                                | cfg_we, no wait
//
// a transaction is held in the input register, evaluated and committed to
// the alarm state as it moves on; an item that raises no alert finishes
// there, so one transaction per cycle is taken unless an item with alerts
// waits on the result register, which it holds for its n alerts (n up to 6);
// the next item is evaluated while its last alert is being taken. reset
// (synchronous, rst_n low) restores the register defaults and clears all
// alarm state; stalls on out_ready back up through the input register.

module climate_alarm_oscillation_monitor import cao_pkg::*; #(
  parameter int CROSS_LIMIT = CROSS_LIMIT_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_opcode,
  input  wire logic signed [TEMP_W-1:0] in_temperature,
  input  wire logic [HUM_W-1:0]         in_humidity,
  input  wire logic                     in_alerts_locked,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [CODE_W-1:0]             out_alert_code,
  output logic                          out_last_alert,
  // configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t        cfg_r;
  item_t       item_r;
  logic        item_v_r;
  logic        advance;
  logic        can_load;
  alert_mask_t mask;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_high <= TEMP_HIGH_RST;
      cfg_r.temp_low  <= TEMP_LOW_RST;
      cfg_r.hum_high  <= HUM_HIGH_RST;
      cfg_r.hum_low   <= HUM_LOW_RST;
      cfg_r.hyst_en   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_HIGH: cfg_r.temp_high <= cfg_data[TEMP_W-1:0];
        REG_TEMP_LOW:  cfg_r.temp_low  <= cfg_data[TEMP_W-1:0];
        REG_HUM_HIGH:  cfg_r.hum_high  <= cfg_data[HUM_W-1:0];
        REG_HUM_LOW:   cfg_r.hum_low   <= cfg_data[HUM_W-1:0];
        REG_HYST_EN:   cfg_r.hyst_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item leaves the input register when it has no alerts or the result
  // register is free (or freeing this cycle)
  assign advance  = item_v_r && ((mask == '0) || can_load);
  assign in_ready = !item_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode        <= in_opcode;
      item_r.temperature   <= in_temperature;
      item_r.humidity      <= in_humidity;
      item_r.alerts_locked <= in_alerts_locked;
    end
  end

  // alarm evaluation and state
  cao_eval #(
    .CROSS_LIMIT (CROSS_LIMIT)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item_r),
    .commit     (advance),
    .alert_mask (mask)
  );

  // result register, one alert per beat in code order
  cao_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && (mask != '0)),
    .load_mask (mask),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_code  (out_alert_code),
    .out_last  (out_last_alert)
  );

endmodule

`default_nettype wire
